### hdl/modular_inverse_fermat_defines.svh
// ----------------------------------------------------------------------------
// modular_inverse_fermat_defines.svh
// Assertion macros shared by the modular inverse block
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_FERMAT_DEFINES_SVH
`define MODULAR_INVERSE_FERMAT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked only while out of reset
`define MFI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MFI_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MFI_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFI_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

### hdl/mfi_pkg.sv
// ----------------------------------------------------------------------------
// mfi_pkg
// Widths, control structs and sequencer states of the modular inverse block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfi_pkg;

  // operand width and bit counter width
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  // reset value of the modulus register
  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(2);

  // request to the modular multiplier
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
    logic [WIDTH-1:0] m;
  } mfi_mul_req_t;

  // status of the modular multiplier
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] result;
  } mfi_mul_stat_t;

  // request to the gcd unit
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] u;
    logic [WIDTH-1:0] v;
  } mfi_gcd_req_t;

  // status of the gcd unit
  typedef struct packed {
    logic busy;
    logic done;
    logic coprime;
  } mfi_gcd_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_GCD_WAIT,
    S_RED,
    S_RED_WAIT,
    S_SQR,
    S_SQR_WAIT,
    S_MUL,
    S_MUL_WAIT,
    S_DONE
  } mfi_state_t;

endpackage

`default_nettype wire

### hdl/mfi_channels.sv
// ----------------------------------------------------------------------------
// mfi_channels
// Valid/ready channel interfaces for request, result and modulus write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// request channel: value
interface mfi_in_if;
  logic                     valid;
  logic                     ready;
  logic [mfi_pkg::WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// result channel: inverse and exists flag
interface mfi_out_if;
  logic                     valid;
  logic                     ready;
  logic [mfi_pkg::WIDTH-1:0] inverse;
  logic                     exists;
  modport source (output valid, output inverse, output exists, input ready);
  modport sink (input valid, input inverse, input exists, output ready);
endinterface

// modulus write channel
interface mfi_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [mfi_pkg::WIDTH-1:0] modulus;
  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

`default_nettype wire

### hdl/mfi_modmul.sv
// ----------------------------------------------------------------------------
// mfi_modmul
// Shift-and-add modular multiplier, one modular add per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modular_inverse_fermat_defines.svh"

module mfi_modmul (
  input  wire                   clk,
  input  wire                   rst_n,
  input  mfi_pkg::mfi_mul_req_t req,
  output mfi_pkg::mfi_mul_stat_t stat
);

  logic [mfi_pkg::WIDTH-1:0] acc_r, acc_nxt;
  logic [mfi_pkg::WIDTH-1:0] x_r, x_nxt;
  logic [mfi_pkg::WIDTH-1:0] y_r, y_nxt;
  logic [mfi_pkg::WIDTH-1:0] m_r, m_nxt;
  logic [mfi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      phase_r, phase_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [mfi_pkg::WIDTH-1:0] op_b;
  logic [mfi_pkg::WIDTH-1:0] room;
  logic [mfi_pkg::WIDTH-1:0] sum;

  // shared modular adder: doubling in phase 0, adding x in phase 1
  assign op_b = phase_r ? x_r : acc_r;
  assign room = m_r - op_b;
  assign sum  = (acc_r >= room) ? (acc_r - room) : (acc_r + op_b);

  // bit sequencing, multiplier bits taken from the top
  always_comb begin
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      acc_nxt   = '0;
      x_nxt     = req.x;
      y_nxt     = req.y;
      m_nxt     = req.m;
      cnt_nxt   = mfi_pkg::CNT_W'(mfi_pkg::WIDTH - 1);
      phase_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum;
      if (!phase_r && y_r[mfi_pkg::WIDTH-1]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        y_nxt     = y_r << 1;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - mfi_pkg::CNT_W'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    m_r     <= m_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
  end

  assign stat.busy   = busy_r;
  assign stat.done   = done_r;
  assign stat.result = acc_r;

  // checks
  `MFI_ASSERT(a_mul_residue, clk, rst_n, done_r |-> (acc_r < m_r), "product not reduced")
  `MFI_ASSERT(a_mul_start, clk, rst_n, req.start |=> (busy_r && !done_r), "start not taken")
  `MFI_ASSERT(a_mul_done_end, clk, rst_n, done_r |-> !busy_r, "done while still busy")

endmodule

`default_nettype wire

### hdl/mfi_gcd.sv
// ----------------------------------------------------------------------------
// mfi_gcd
// Binary gcd unit deciding whether two operands are coprime
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfi_gcd (
  input  wire                    clk,
  input  wire                    rst_n,
  input  mfi_pkg::mfi_gcd_req_t  req,
  output mfi_pkg::mfi_gcd_stat_t stat
);

  logic [mfi_pkg::WIDTH-1:0] u_r, u_nxt;
  logic [mfi_pkg::WIDTH-1:0] v_r, v_nxt;
  logic                      even_r, even_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic                      cop_r, cop_nxt;

  logic                      u_ge_v;
  logic [mfi_pkg::WIDTH-1:0] dif;

  // shared compare and subtract
  assign u_ge_v = (u_r >= v_r);
  assign dif    = u_ge_v ? (u_r - v_r) : (v_r - u_r);

  // one shift or subtract step per cycle
  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    even_nxt = even_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cop_nxt  = cop_r;
    if (req.start) begin
      u_nxt    = req.u;
      v_nxt    = req.v;
      even_nxt = !req.u[0] && !req.v[0];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (even_r) begin
        // common factor of two
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cop_nxt  = 1'b0;
      end else if (u_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cop_nxt  = (v_r == mfi_pkg::WIDTH'(1));
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_ge_v) begin
        u_nxt = dif;
      end else begin
        v_nxt = dif;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    even_r <= even_nxt;
    cop_r  <= cop_nxt;
  end

  assign stat.busy    = busy_r;
  assign stat.done    = done_r;
  assign stat.coprime = cop_r;

endmodule

`default_nettype wire

### hdl/modular_inverse_fermat.sv
// ----------------------------------------------------------------------------
// modular_inverse_fermat
// Modular inverse by Fermat's little theorem against a written modulus
// ----------------------------------------------------------------------------
// Each request takes a value a and, against the modulus m in the register,
// returns a^(m-2) mod m with exists high when gcd(a, m) is 1, and inverse 0
// with exists low otherwise (also when m is below 2). One request is worked
// at a time: in_chan.ready is high only while the sequencer is idle, and one
// finished result may wait in the output register while the next request is
// taken. The single shift-and-add modular multiplier does one modular add
// per cycle. A request costs a binary gcd pass, one reduction of a, then for
// each of the WIDTH exponent bits a squaring and, for a set bit of m-2, a
// multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modular_inverse_fermat_defines.svh"

module modular_inverse_fermat (
  input  wire             clk,
  input  wire             rst_n,
  mfi_in_if.sink          in_chan,
  mfi_out_if.source       out_chan,
  mfi_cfg_if.sink         cfg_chan
);

  mfi_pkg::mfi_state_t       state_r, state_nxt;
  logic [mfi_pkg::WIDTH-1:0] mod_r;
  logic [mfi_pkg::WIDTH-1:0] a_r, a_nxt;
  logic [mfi_pkg::WIDTH-1:0] m_r, m_nxt;
  logic [mfi_pkg::WIDTH-1:0] base_r, base_nxt;
  logic [mfi_pkg::WIDTH-1:0] acc_r, acc_nxt;
  logic [mfi_pkg::WIDTH-1:0] e_r, e_nxt;
  logic [mfi_pkg::CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [mfi_pkg::WIDTH-1:0] inv_r, inv_nxt;
  logic                      ok_r, ok_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [mfi_pkg::WIDTH-1:0] out_inv_r, out_inv_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic                      bit_last;

  mfi_pkg::mfi_mul_req_t  mul_req;
  mfi_pkg::mfi_mul_stat_t mul_stat;
  mfi_pkg::mfi_gcd_req_t  gcd_req;
  mfi_pkg::mfi_gcd_stat_t gcd_stat;

  // shared units
  mfi_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .stat  (mul_stat)
  );

  mfi_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .stat  (gcd_stat)
  );

  // modulus register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mfi_pkg::MOD_RESET;
    end else if (cfg_chan.valid) begin
      mod_r <= cfg_chan.modulus;
    end
  end

  // unit requests
  assign gcd_req.start = (state_r == mfi_pkg::S_GCD);
  assign gcd_req.u     = a_r;
  assign gcd_req.v     = m_r;

  assign mul_req.start = (state_r == mfi_pkg::S_RED) || (state_r == mfi_pkg::S_SQR) ||
                         (state_r == mfi_pkg::S_MUL);
  assign mul_req.x     = (state_r == mfi_pkg::S_RED) ? mfi_pkg::WIDTH'(1) : acc_r;
  assign mul_req.y     = (state_r == mfi_pkg::S_RED) ? a_r :
                         (state_r == mfi_pkg::S_SQR) ? acc_r : base_r;
  assign mul_req.m     = m_r;

  assign bit_last = (bcnt_r == '0);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    m_nxt         = m_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    bcnt_nxt      = bcnt_r;
    inv_nxt       = inv_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_inv_nxt   = out_inv_r;
    out_ok_nxt    = out_ok_r;
    unique case (state_r)
      mfi_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          a_nxt = in_chan.value;
          m_nxt = mod_r;
          if (mod_r < mfi_pkg::WIDTH'(2)) begin
            inv_nxt   = '0;
            ok_nxt    = 1'b0;
            state_nxt = mfi_pkg::S_DONE;
          end else begin
            state_nxt = mfi_pkg::S_GCD;
          end
        end
      end
      mfi_pkg::S_GCD: begin
        state_nxt = mfi_pkg::S_GCD_WAIT;
      end
      mfi_pkg::S_GCD_WAIT: begin
        if (gcd_stat.done) begin
          if (gcd_stat.coprime) begin
            state_nxt = mfi_pkg::S_RED;
          end else begin
            inv_nxt   = '0;
            ok_nxt    = 1'b0;
            state_nxt = mfi_pkg::S_DONE;
          end
        end
      end
      mfi_pkg::S_RED: begin
        state_nxt = mfi_pkg::S_RED_WAIT;
      end
      mfi_pkg::S_RED_WAIT: begin
        // base = a mod m, then start the power at 1
        if (mul_stat.done) begin
          base_nxt  = mul_stat.result;
          acc_nxt   = mfi_pkg::WIDTH'(1);
          e_nxt     = m_r - mfi_pkg::WIDTH'(2);
          bcnt_nxt  = mfi_pkg::CNT_W'(mfi_pkg::WIDTH - 1);
          state_nxt = mfi_pkg::S_SQR;
        end
      end
      mfi_pkg::S_SQR: begin
        state_nxt = mfi_pkg::S_SQR_WAIT;
      end
      mfi_pkg::S_SQR_WAIT: begin
        if (mul_stat.done) begin
          acc_nxt = mul_stat.result;
          if (e_r[mfi_pkg::WIDTH-1]) begin
            state_nxt = mfi_pkg::S_MUL;
          end else if (bit_last) begin
            inv_nxt   = mul_stat.result;
            ok_nxt    = 1'b1;
            state_nxt = mfi_pkg::S_DONE;
          end else begin
            e_nxt     = e_r << 1;
            bcnt_nxt  = bcnt_r - mfi_pkg::CNT_W'(1);
            state_nxt = mfi_pkg::S_SQR;
          end
        end
      end
      mfi_pkg::S_MUL: begin
        state_nxt = mfi_pkg::S_MUL_WAIT;
      end
      mfi_pkg::S_MUL_WAIT: begin
        if (mul_stat.done) begin
          acc_nxt = mul_stat.result;
          if (bit_last) begin
            inv_nxt   = mul_stat.result;
            ok_nxt    = 1'b1;
            state_nxt = mfi_pkg::S_DONE;
          end else begin
            e_nxt     = e_r << 1;
            bcnt_nxt  = bcnt_r - mfi_pkg::CNT_W'(1);
            state_nxt = mfi_pkg::S_SQR;
          end
        end
      end
      mfi_pkg::S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = inv_r;
          out_ok_nxt    = ok_r;
          state_nxt     = mfi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mfi_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfi_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    m_r       <= m_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    e_r       <= e_nxt;
    bcnt_r    <= bcnt_nxt;
    inv_r     <= inv_nxt;
    ok_r      <= ok_nxt;
    out_inv_r <= out_inv_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign in_chan.ready    = (state_r == mfi_pkg::S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.inverse = out_inv_r;
  assign out_chan.exists  = out_ok_r;

  // checks
  `MFI_ASSERT(a_none_zero, clk, rst_n,
              (out_chan.valid && !out_chan.exists) |-> (out_chan.inverse == '0),
              "inverse set without exists")
  `MFI_ASSERT(a_one_at_time, clk, rst_n,
              (in_chan.valid && in_chan.ready) |=> !in_chan.ready,
              "second request taken while busy")
  `MFI_ASSERT(a_mul_free, clk, rst_n,
              mul_req.start |-> (!mul_stat.busy && !gcd_stat.busy),
              "unit started while busy")
  `MFI_ASSERT_RST(a_reset_out, clk, !rst_n |=> !out_chan.valid, "result valid after reset")

endmodule

`default_nettype wire

### bench/modular_inverse_fermat_tb.sv
// ----------------------------------------------------------------------------
// modular_inverse_fermat_tb
// Self-checking bench for the Fermat modular inverse block
// ----------------------------------------------------------------------------
// Values are sent against a series of written moduli: primes, composites,
// the smallest and largest moduli, and moduli below two. A local predictor
// finds the gcd by Euclid's remainder method and the power a^(m-2) mod m by
// square-and-multiply with double-width products. Every result is checked
// in order against the predicted one. Both channels idle in random bursts,
// and one long receiver hold backs the block up into its request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_fermat_tb;

  localparam int WIDTH         = mfi_pkg::WIDTH;
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  // allowance per request, with margin over the slowest request
  localparam int ITEM_CYCLES   = 7000;
  localparam int ITEMS_MAX     = 650;
  localparam int LONG_HOLD     = 20000;
  localparam int CYCLE_LIMIT   = 3 * ITEMS_MAX * ITEM_CYCLES + 10 * LONG_HOLD;
  localparam int TAIL_CYCLES   = ITEM_CYCLES;

  // one predicted result
  typedef struct {
    logic [WIDTH-1:0] inverse;
    logic             exists;
  } inv_result_t;

  logic clk;
  logic rst_n;

  mfi_in_if  in_ch ();
  mfi_out_if out_ch ();
  mfi_cfg_if cfg_ch ();

  modular_inverse_fermat u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // bench state
  logic [WIDTH-1:0] value_q [$];
  inv_result_t      inverse_q [$];
  logic [WIDTH-1:0] cur_modulus = mfi_pkg::MOD_RESET;
  int               items_open  = 0;
  int               fail_count  = 0;
  int               cycle_count = 0;
  int               idle_rate   = 0;
  bit               long_hold_req = 1'b0;
  int               send_gap  = 0;
  int               recv_stall = 0;

  // clock
  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // (x * y) mod m at full double width
  function automatic logic [WIDTH-1:0] mod_mul(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] prod;
    prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
    return WIDTH'(prod % {{WIDTH{1'b0}}, m});
  endfunction

  // gcd check, then a^(m-2) mod m over all exponent bits from the top
  function automatic inv_result_t predict_inverse(input logic [WIDTH-1:0] a,
                                                  input logic [WIDTH-1:0] m);
    inv_result_t      r;
    logic [WIDTH-1:0] u;
    logic [WIDTH-1:0] v;
    logic [WIDTH-1:0] t;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] acc;
    r.inverse = '0;
    r.exists  = 1'b0;
    // moduli below two never have an inverse
    if (m < WIDTH'(2))
      return r;
    u = a;
    v = m;
    while (u != '0) begin
      t = v % u;
      v = u;
      u = t;
    end
    if (v != WIDTH'(1))
      return r;
    e    = m - WIDTH'(2);
    base = a % m;
    acc  = WIDTH'(1);
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = mod_mul(acc, acc, m);
      if (e[i])
        acc = mod_mul(acc, base, m);
    end
    r.inverse = acc;
    r.exists  = 1'b1;
    return r;
  endfunction

  // value mix that favors residues, multiples and edges of the modulus
  function automatic logic [WIDTH-1:0] pick_value(input logic [WIDTH-1:0] m);
    case ($urandom_range(0, 5))
      0: return WIDTH'($urandom());
      1: return WIDTH'($urandom_range(0, 20));
      2: return (m >= WIDTH'(2)) ? WIDTH'($urandom_range(0, m - 1)) : WIDTH'($urandom());
      3: return m * WIDTH'($urandom_range(0, 7));
      4: return m + WIDTH'($urandom_range(0, 2)) - WIDTH'(1);
      default: begin
        if ($urandom_range(0, 1) == 0)
          return WIDTH'(1) << $urandom_range(0, WIDTH - 1);
        else
          return ~(WIDTH'(1) << $urandom_range(0, WIDTH - 1));
      end
    endcase
  endfunction

  // request driver: presents queued values, idles in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      send_gap    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        inverse_q.push_back(predict_inverse(in_ch.value, cur_modulus));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (value_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= value_q.pop_front();
          if (idle_rate > 0 && $urandom_range(1, 16) <= idle_rate)
            send_gap = $urandom_range(1, 19);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each result, drives ready with stalls and holds
  always @(posedge clk) begin
    inv_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (inverse_q.size() == 0) begin
          $error("result with no request waiting: inverse %h exists %b",
                 out_ch.inverse, out_ch.exists);
          fail_count++;
        end else begin
          want = inverse_q.pop_front();
          if (out_ch.inverse !== want.inverse) begin
            $error("inverse mismatch: expected %h, actual %h",
                   want.inverse, out_ch.inverse);
            fail_count++;
          end
          if (out_ch.exists !== want.exists) begin
            $error("exists mismatch: expected %b, actual %b",
                   want.exists, out_ch.exists);
            fail_count++;
          end
          items_open--;
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        recv_stall    = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_rate > 0 && $urandom_range(1, 16) <= idle_rate)
          recv_stall = $urandom_range(1, 19);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (items_open != 0)
      @(posedge clk);
  endtask

  task automatic queue_value(input logic [WIDTH-1:0] v);
    value_q.push_back(v);
    items_open++;
  endtask

  // modulus write, only once every result is back
  task automatic write_modulus(input logic [WIDTH-1:0] m);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_modulus = m;
  endtask

  task automatic random_phase(input logic [WIDTH-1:0] m, input int count,
                              input bit hold);
    write_modulus(m);
    idle_rate = $urandom_range(0, 4);
    if (hold)
      long_hold_req = 1'b1;
    for (int i = 0; i < count; i++)
      queue_value(pick_value(m));
  endtask

  // stimulus sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.modulus = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: modulus two, exponent zero
    idle_rate = 0;
    write_modulus(WIDTH'(2));
    queue_value('0);
    queue_value(WIDTH'(1));
    queue_value(WIDTH'(2));
    queue_value(WIDTH'(3));
    queue_value('1);
    // moduli below two report no inverse
    write_modulus('0);
    queue_value('0);
    queue_value(WIDTH'(5));
    write_modulus(WIDTH'(1));
    queue_value(WIDTH'(1));
    queue_value('1);
    // largest prime: zero, one, two, m-1, m, above m
    write_modulus(WIDTH'(32'hFFFF_FFFB));
    queue_value('0);
    queue_value(WIDTH'(1));
    queue_value(WIDTH'(2));
    queue_value(WIDTH'(32'hFFFF_FFFA));
    queue_value(WIDTH'(32'hFFFF_FFFB));
    queue_value('1);
    // composite modulus: shared factor and coprime value
    write_modulus(WIDTH'(15));
    queue_value(WIDTH'(3));
    queue_value(WIDTH'(7));
    queue_value(WIDTH'(30));
    queue_value('0);
    // all-ones modulus, not prime
    write_modulus('1);
    queue_value(WIDTH'(32'h8000_0000));
    queue_value(WIDTH'(32'h5555_5555));
    queue_value(WIDTH'(32'hAAAA_AAAA));

    // random phases over primes, composites and random moduli
    random_phase(WIDTH'(7), 60, 1'b0);
    random_phase(WIDTH'(65537), 60, 1'b1);
    random_phase(WIDTH'(32'h7FFF_FFFF), 60, 1'b0);
    random_phase(WIDTH'(32'hFFFF_FFFB), 70, 1'b0);
    random_phase('1, 60, 1'b0);
    random_phase(WIDTH'(3), 30, 1'b0);
    random_phase(WIDTH'($urandom_range(2, 200)), 60, 1'b0);
    random_phase(WIDTH'($urandom()) | WIDTH'(2), 70, 1'b0);
    random_phase(WIDTH'(1000003), 60, 1'b0);

    // last stretch with no idling on either side
    write_modulus(WIDTH'($urandom()) | WIDTH'(1));
    idle_rate = 0;
    for (int i = 0; i < 50; i++)
      queue_value(pick_value(cur_modulus));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && inverse_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### modular_inverse_fermat.f
+incdir+hdl
hdl/mfi_pkg.sv
hdl/mfi_channels.sv
hdl/mfi_modmul.sv
hdl/mfi_gcd.sv
hdl/modular_inverse_fermat.sv
bench/modular_inverse_fermat_tb.sv
